// ----- design/p2bp_pkg.sv -----
// Shared types and constants for the power-of-two buffer pool.
package p2bp_pkg;

    localparam int SIZE_W     = 32;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;
    localparam int CLASS_W    = 5;
    localparam int LOG_W      = 6;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam int LOG2_CFG_W   = 4;
    localparam int ACTIVE_CFG_W = 5;
    localparam int DEPTH_CFG_W  = 7;

    // first class of each depth tier (half, quarter, eighth of base depth)
    localparam int TIER_HALF_FIRST    = 8;
    localparam int TIER_QUARTER_FIRST = 11;
    localparam int TIER_EIGHTH_FIRST  = 15;

    localparam logic [LOG2_CFG_W-1:0]   RST_SMALLEST_LOG2 = 4'd5;
    localparam logic [ACTIVE_CFG_W-1:0] RST_ACTIVE        = 5'd18;
    localparam logic [DEPTH_CFG_W-1:0]  RST_BASE_DEPTH    = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_RESIZE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FROM_POOL  = 3'd0,
        ST_NEED_FRESH = 3'd1,
        ST_IN_PLACE   = 3'd2,
        ST_PUSHED     = 3'd3,
        ST_RELEASE    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_SMALLEST_LOG2 = 2'd0,
        REG_ACTIVE        = 2'd1,
        REG_BASE_DEPTH    = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_POP,
        S_PUSH,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [LOG2_CFG_W-1:0]   smallest_log2;
        logic [ACTIVE_CFG_W-1:0] active;
        logic [DEPTH_CFG_W-1:0]  base_depth;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic find;
        logic pop;
        logic push;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic in_place;
        logic out_busy;
    } sts_t;

endpackage

// ----- design/p2bp_req_if.sv -----
// Request channel: valid/ready handshake with the request word.
interface p2bp_req_if;
    logic                          valid;
    logic                          ready;
    logic [p2bp_pkg::OP_W-1:0]     operation;
    logic [p2bp_pkg::SIZE_W-1:0]   request_size;
    logic [p2bp_pkg::SIZE_W-1:0]   held_handle;
    logic [p2bp_pkg::SIZE_W-1:0]   held_real_size;

    modport source (
        output valid, operation, request_size, held_handle, held_real_size,
        input  ready
    );
    modport sink (
        input  valid, operation, request_size, held_handle, held_real_size,
        output ready
    );
endinterface

// ----- design/p2bp_rsp_if.sv -----
// Response channel: valid/ready handshake with the result word.
interface p2bp_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [p2bp_pkg::STATUS_W-1:0]   status;
    logic [p2bp_pkg::SIZE_W-1:0]     out_handle;
    logic [p2bp_pkg::SIZE_W-1:0]     out_real_size;
    logic [p2bp_pkg::SIZE_W-1:0]     out_size;
    logic [p2bp_pkg::CLASS_W-1:0]    class_index;
    logic                            old_released;

    modport source (
        output valid, status, out_handle, out_real_size, out_size, class_index,
               old_released,
        input  ready
    );
    modport sink (
        input  valid, status, out_handle, out_real_size, out_size, class_index,
               old_released,
        output ready
    );
endinterface

// ----- design/p2bp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module p2bp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/p2bp_regs.sv -----
// APB configuration registers of the buffer pool.
module p2bp_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [p2bp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [p2bp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [p2bp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output p2bp_pkg::cfg_t                      cfg
);

    logic [p2bp_pkg::LOG2_CFG_W-1:0]   smallest_reg;
    logic [p2bp_pkg::ACTIVE_CFG_W-1:0] active_reg;
    logic [p2bp_pkg::DEPTH_CFG_W-1:0]  base_reg;
    p2bp_pkg::reg_idx_t                idx;
    logic                              wr;

    assign idx    = p2bp_pkg::reg_idx_t'(paddr[p2bp_pkg::APB_ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smallest_reg <= p2bp_pkg::RST_SMALLEST_LOG2;
            active_reg   <= p2bp_pkg::RST_ACTIVE;
            base_reg     <= p2bp_pkg::RST_BASE_DEPTH;
        end
        else if (wr)
        begin
            case (idx)
                p2bp_pkg::REG_SMALLEST_LOG2:
                    smallest_reg <= pwdata[p2bp_pkg::LOG2_CFG_W-1:0];
                p2bp_pkg::REG_ACTIVE:
                    active_reg <= pwdata[p2bp_pkg::ACTIVE_CFG_W-1:0];
                p2bp_pkg::REG_BASE_DEPTH:
                    base_reg <= pwdata[p2bp_pkg::DEPTH_CFG_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            p2bp_pkg::REG_SMALLEST_LOG2: prdata = p2bp_pkg::APB_DATA_W'(smallest_reg);
            p2bp_pkg::REG_ACTIVE:        prdata = p2bp_pkg::APB_DATA_W'(active_reg);
            p2bp_pkg::REG_BASE_DEPTH:    prdata = p2bp_pkg::APB_DATA_W'(base_reg);
            default:                     prdata = '0;
        endcase
    end

    assign cfg.smallest_log2 = smallest_reg;
    assign cfg.active        = active_reg;
    assign cfg.base_depth    = base_reg;

endmodule

// ----- design/p2bp_ctrl.sv -----
// Sequencer: steps one request through class lookup, pop, push and result.
module p2bp_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [p2bp_pkg::OP_W-1:0]  in_op,
    output logic                       in_ready,
    input  p2bp_pkg::sts_t             sts,
    output p2bp_pkg::cmd_t             cmd
);

    p2bp_pkg::state_t state_reg;
    p2bp_pkg::state_t state_next;
    logic             op_known;

    assign op_known = in_op inside {p2bp_pkg::OP_ALLOC, p2bp_pkg::OP_FREE,
                                    p2bp_pkg::OP_RESIZE};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= p2bp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            p2bp_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                // unknown opcodes are taken and dropped
                if (in_valid && op_known)
                begin
                    cmd.load   = 1'b1;
                    state_next = p2bp_pkg::S_FIND;
                end
            end
            p2bp_pkg::S_FIND:
            begin
                cmd.find = 1'b1;
                if (sts.op == p2bp_pkg::OP_FREE)
                begin
                    state_next = p2bp_pkg::S_PUSH;
                end
                else if (sts.op == p2bp_pkg::OP_RESIZE && sts.in_place)
                begin
                    state_next = p2bp_pkg::S_OUT;
                end
                else
                begin
                    state_next = p2bp_pkg::S_POP;
                end
            end
            p2bp_pkg::S_POP:
            begin
                cmd.pop = 1'b1;
                // a moving resize returns the old buffer after the pop
                state_next = (sts.op == p2bp_pkg::OP_RESIZE) ? p2bp_pkg::S_PUSH
                                                               : p2bp_pkg::S_OUT;
            end
            p2bp_pkg::S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = p2bp_pkg::S_OUT;
            end
            p2bp_pkg::S_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = p2bp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = p2bp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/p2bp_dp.sv -----
// Datapath: class lookup, per-class fill counters, handle stack memory, result register.
module p2bp_dp #(
    parameter int MAX_CLASSES = 18,
    parameter int STACK_DEPTH = 64,
    parameter int HANDLE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  p2bp_pkg::cfg_t                    cfg,
    input  p2bp_pkg::cmd_t                    cmd,
    output p2bp_pkg::sts_t                    sts,
    input  logic [p2bp_pkg::OP_W-1:0]         operation,
    input  logic [p2bp_pkg::SIZE_W-1:0]       request_size,
    input  logic [p2bp_pkg::SIZE_W-1:0]       held_handle,
    input  logic [p2bp_pkg::SIZE_W-1:0]       held_real_size,
    input  logic                              rsp_ready,
    output logic                              rsp_valid,
    output logic [p2bp_pkg::STATUS_W-1:0]     status,
    output logic [p2bp_pkg::SIZE_W-1:0]       out_handle,
    output logic [p2bp_pkg::SIZE_W-1:0]       out_real_size,
    output logic [p2bp_pkg::SIZE_W-1:0]       out_size,
    output logic [p2bp_pkg::CLASS_W-1:0]      class_index,
    output logic                              old_released
);

    localparam int SW        = p2bp_pkg::SIZE_W;
    localparam int LW        = p2bp_pkg::LOG_W;
    localparam int CW        = $clog2(MAX_CLASSES + 1);
    localparam int IW        = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int FW        = $clog2(STACK_DEPTH + 1);
    localparam int MEM_DEPTH = MAX_CLASSES * STACK_DEPTH;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [AW-1:0] ROW_STRIDE = AW'(STACK_DEPTH);

    // ceil(log2(w)); 0 and 1 both map to 0
    function automatic logic [LW-1:0] ceil_log2(input logic [SW-1:0] w);
        logic [SW-1:0] v;
        logic [LW-1:0] r;
        v = w - SW'(1);
        r = '0;
        for (int i = 0; i < SW; i++)
        begin
            if (v[i])
            begin
                r = LW'(i + 1);
            end
        end
        if (w <= SW'(1))
        begin
            r = '0;
        end
        return r;
    endfunction

    // smallest class whose size 2^(s+k) covers 2^lg; n when none fits
    function automatic logic [CW-1:0] class_of(input logic [LW-1:0] lg,
                                               input logic [p2bp_pkg::LOG2_CFG_W-1:0] s,
                                               input logic [CW-1:0] n);
        logic [LW-1:0] k;
        logic [CW-1:0] r;
        k = (lg > LW'(s)) ? lg - LW'(s) : '0;
        if ((LW + 1)'(k) >= (LW + 1)'(n))
        begin
            r = n;
        end
        else
        begin
            r = CW'(k);
        end
        return r;
    endfunction

    p2bp_pkg::op_t        op_reg;
    logic [SW-1:0]        req_reg;
    logic [SW-1:0]        held_reg;
    logic [SW-1:0]        hreal_reg;
    logic [CW-1:0]        cls_req_reg;
    logic [CW-1:0]        cls_held_reg;
    logic [SW-1:0]        real_req_reg;
    logic                 popped_reg;
    logic                 pushed_reg;
    logic                 rd_pending_reg;
    logic [SW-1:0]        hnd_reg;
    logic [FW-1:0]        fill_reg [MAX_CLASSES];

    logic                 rsp_valid_reg;
    p2bp_pkg::status_t    status_reg;
    logic [SW-1:0]        out_handle_reg;
    logic [SW-1:0]        out_real_reg;
    logic [SW-1:0]        out_size_reg;
    logic [p2bp_pkg::CLASS_W-1:0] class_reg;
    logic                 released_reg;

    logic [CW-1:0]        n_cls;
    logic [LW-1:0]        lg_req;
    logic [LW-1:0]        lg_held;
    logic [CW-1:0]        cls_req;
    logic [LW-1:0]        exp_req;
    logic [SW-1:0]        real_req;
    logic                 in_place;

    logic [IW-1:0]        k_req;
    logic [IW-1:0]        k_held;
    logic [FW-1:0]        fill_req;
    logic [FW-1:0]        fill_held;
    logic                 pop_ok;
    logic                 push_ok;
    logic [p2bp_pkg::DEPTH_CFG_W-1:0] tier_depth;
    logic [31:0]          limit;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [HANDLE_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [HANDLE_BITS-1:0] mem_rdata;
    logic [SW-1:0]        hnd_sel;

    p2bp_pkg::status_t    res_status;
    logic [SW-1:0]        res_handle;
    logic [SW-1:0]        res_real;
    logic [SW-1:0]        res_size;
    logic [CW-1:0]        res_cls;
    logic                 res_rel;

    // effective class count
    assign n_cls = (32'(cfg.active) > 32'(MAX_CLASSES)) ? CW'(MAX_CLASSES) : CW'(cfg.active);

    // class lookup
    always_comb
    begin
        lg_req  = ceil_log2(req_reg);
        lg_held = ceil_log2(hreal_reg);
        cls_req = class_of(lg_req, cfg.smallest_log2, n_cls);
        exp_req = (lg_req > LW'(cfg.smallest_log2)) ? lg_req : LW'(cfg.smallest_log2);
        if (cls_req == n_cls)
        begin
            real_req = req_reg;
        end
        else if (exp_req >= LW'(SW))
        begin
            real_req = '1;
        end
        else
        begin
            real_req = SW'(1) << exp_req[$clog2(SW)-1:0];
        end
    end

    assign in_place = (req_reg <= hreal_reg);

    // stack pop / push
    assign k_req     = cls_req_reg[IW-1:0];
    assign k_held    = cls_held_reg[IW-1:0];
    assign fill_req  = (cls_req_reg < n_cls) ? fill_reg[k_req] : '0;
    assign fill_held = (cls_held_reg < n_cls) ? fill_reg[k_held] : '0;
    assign pop_ok    = (cls_req_reg < n_cls) && (fill_req != '0);

    always_comb
    begin
        if (32'(cls_held_reg) >= p2bp_pkg::TIER_EIGHTH_FIRST)
        begin
            tier_depth = cfg.base_depth >> 3;
        end
        else if (32'(cls_held_reg) >= p2bp_pkg::TIER_QUARTER_FIRST)
        begin
            tier_depth = cfg.base_depth >> 2;
        end
        else if (32'(cls_held_reg) >= p2bp_pkg::TIER_HALF_FIRST)
        begin
            tier_depth = cfg.base_depth >> 1;
        end
        else
        begin
            tier_depth = cfg.base_depth;
        end
        limit = (32'(tier_depth) > 32'(STACK_DEPTH)) ? 32'(STACK_DEPTH) : 32'(tier_depth);
    end

    assign push_ok = (cls_held_reg < n_cls) && (32'(fill_held) < limit);

    assign mem_re    = cmd.pop && pop_ok;
    assign mem_raddr = AW'(k_req) * ROW_STRIDE + AW'(fill_req - FW'(1));
    assign mem_we    = cmd.push && push_ok;
    assign mem_waddr = AW'(k_held) * ROW_STRIDE + AW'(fill_held);
    assign mem_wdata = HANDLE_BITS'(held_reg);

    p2bp_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_stacks (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // read data is valid the cycle after the pop
    assign hnd_sel = rd_pending_reg ? SW'(mem_rdata) : hnd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CLASSES; i++)
            begin
                fill_reg[i] <= '0;
            end
            rd_pending_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.pop && pop_ok)
            begin
                fill_reg[k_req] <= fill_req - FW'(1);
            end
            if (cmd.push && push_ok)
            begin
                fill_reg[k_held] <= fill_held + FW'(1);
            end
            rd_pending_reg <= mem_re;
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        res_status = p2bp_pkg::ST_NEED_FRESH;
        res_handle = '0;
        res_real   = real_req_reg;
        res_size   = req_reg;
        res_cls    = cls_req_reg;
        res_rel    = 1'b0;
        case (op_reg)
            p2bp_pkg::OP_FREE:
            begin
                res_status = pushed_reg ? p2bp_pkg::ST_PUSHED : p2bp_pkg::ST_RELEASE;
                res_handle = held_reg;
                res_real   = hreal_reg;
                res_size   = '0;
                res_cls    = cls_held_reg;
            end
            p2bp_pkg::OP_RESIZE:
            begin
                if (in_place)
                begin
                    res_status = p2bp_pkg::ST_IN_PLACE;
                    res_handle = held_reg;
                    res_real   = hreal_reg;
                    res_cls    = cls_held_reg;
                end
                else
                begin
                    res_status = popped_reg ? p2bp_pkg::ST_FROM_POOL
                                            : p2bp_pkg::ST_NEED_FRESH;
                    res_handle = popped_reg ? hnd_sel : '0;
                    res_rel    = !pushed_reg;
                end
            end
            default:
            begin
                res_status = popped_reg ? p2bp_pkg::ST_FROM_POOL : p2bp_pkg::ST_NEED_FRESH;
                res_handle = popped_reg ? hnd_sel : '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= p2bp_pkg::op_t'(operation);
            req_reg   <= request_size;
            held_reg  <= held_handle;
            hreal_reg <= held_real_size;
        end
        if (cmd.find)
        begin
            cls_req_reg  <= cls_req;
            cls_held_reg <= class_of(lg_held, cfg.smallest_log2, n_cls);
            real_req_reg <= real_req;
        end
        if (cmd.pop)
        begin
            popped_reg <= pop_ok;
        end
        if (cmd.push)
        begin
            pushed_reg <= push_ok;
        end
        if (rd_pending_reg)
        begin
            hnd_reg <= SW'(mem_rdata);
        end
        if (cmd.out_load)
        begin
            status_reg     <= res_status;
            out_handle_reg <= res_handle;
            out_real_reg   <= res_real;
            out_size_reg   <= res_size;
            class_reg      <= p2bp_pkg::CLASS_W'(res_cls);
            released_reg   <= res_rel;
        end
    end

    assign sts.op       = op_reg;
    assign sts.in_place = in_place;
    assign sts.out_busy = rsp_valid_reg && !rsp_ready;

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign out_handle    = out_handle_reg;
    assign out_real_size = out_real_reg;
    assign out_size      = out_size_reg;
    assign class_index   = class_reg;
    assign old_released  = released_reg;

endmodule

// ----- design/pow2_size_class_buffer_pool.sv -----
// Power-of-two size-class buffer pool: per-class LIFO stacks of buffer handles.
// One request word at a time: an in-place resize goes through lookup and result, allocate
// adds a pop, free adds a push, and a moving resize adds a pop and then a push.
// The sequencer takes one step per cycle; a result waiting on the output holds it.
// Reset clears every fill count at once and loads the configuration defaults;
// stack contents are not cleared, so requests are taken from the first cycle.
module pow2_size_class_buffer_pool #(
    parameter int MAX_CLASSES = 18,
    parameter int STACK_DEPTH = 64,
    parameter int HANDLE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [p2bp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [p2bp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [p2bp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    p2bp_req_if.sink                            req,
    p2bp_rsp_if.source                          rsp
);

    p2bp_pkg::cfg_t cfg;
    p2bp_pkg::cmd_t cmd;
    p2bp_pkg::sts_t sts;

    p2bp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    p2bp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.operation),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    p2bp_dp #(
        .MAX_CLASSES (MAX_CLASSES),
        .STACK_DEPTH (STACK_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .sts            (sts),
        .operation      (req.operation),
        .request_size   (req.request_size),
        .held_handle    (req.held_handle),
        .held_real_size (req.held_real_size),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .status         (rsp.status),
        .out_handle     (rsp.out_handle),
        .out_real_size  (rsp.out_real_size),
        .out_size       (rsp.out_size),
        .class_index    (rsp.class_index),
        .old_released   (rsp.old_released)
    );

endmodule

// ----- test/tb_pow2_size_class_buffer_pool.sv -----
// Self-checking testbench for the power-of-two size-class buffer pool.
`timescale 1ns / 1ps

module tb_pow2_size_class_buffer_pool;

    localparam int POOL_CLASSES = 18;
    localparam int POOL_DEPTH   = 64;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASE_WORDS   = 150;
    localparam int SW = p2bp_pkg::SIZE_W;
    localparam int OW = p2bp_pkg::OP_W;
    localparam logic [OW-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        p2bp_pkg::status_t              status;
        logic [SW-1:0]                  handle;
        logic [SW-1:0]                  buf_size;
        logic [SW-1:0]                  size;
        logic [p2bp_pkg::CLASS_W-1:0]   cls;
        logic                           released;
    } reply_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [p2bp_pkg::APB_ADDR_W-1:0] paddr;
    logic [p2bp_pkg::APB_DATA_W-1:0] pwdata;
    logic [p2bp_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    p2bp_req_if req_ch ();
    p2bp_rsp_if rsp_ch ();

    pow2_size_class_buffer_pool #(
        .MAX_CLASSES (POOL_CLASSES),
        .STACK_DEPTH (POOL_DEPTH),
        .HANDLE_BITS (32)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // shadow configuration and handle stacks of the pool
    logic [p2bp_pkg::LOG2_CFG_W-1:0]   cfg_log2   = p2bp_pkg::RST_SMALLEST_LOG2;
    logic [p2bp_pkg::ACTIVE_CFG_W-1:0] cfg_active = p2bp_pkg::RST_ACTIVE;
    logic [p2bp_pkg::DEPTH_CFG_W-1:0]  cfg_depth  = p2bp_pkg::RST_BASE_DEPTH;
    logic [SW-1:0] stash [POOL_CLASSES][POOL_DEPTH];
    int unsigned stash_fill [POOL_CLASSES];

    reply_t pool_replies_due [$];
    logic [SW-1:0] live_handles [$];
    logic [SW-1:0] live_sizes [$];

    bit calm = 1'b0;
    int fail_count = 0;
    int words_sent = 0;
    int ignored_sent = 0;
    int replies_checked = 0;
    int releases_seen = 0;
    int settings_used = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_pow2_size_class_buffer_pool: FAIL");
        $finish;
    end

    function automatic int unsigned active_count();
        return (cfg_active > POOL_CLASSES) ? POOL_CLASSES : cfg_active;
    endfunction

    function automatic int unsigned depth_cap(input int unsigned k);
        int unsigned d;
        d = cfg_depth;
        if (k >= p2bp_pkg::TIER_EIGHTH_FIRST)
            d = d / 8;
        else if (k >= p2bp_pkg::TIER_QUARTER_FIRST)
            d = d / 4;
        else if (k >= p2bp_pkg::TIER_HALF_FIRST)
            d = d / 2;
        return (d > POOL_DEPTH) ? POOL_DEPTH : d;
    endfunction

    // smallest class covering the size; class size saturates at 32 bits
    function automatic int unsigned lookup_class(input logic [SW-1:0] wanted,
                                                 output logic [SW-1:0] real_sz);
        int unsigned n;
        logic [63:0] csz;
        n = active_count();
        for (int unsigned k = 0; k < n; k++)
        begin
            csz = 64'd1 << (int'(cfg_log2) + k);
            if ({32'd0, wanted} <= csz)
            begin
                real_sz = (csz > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : csz[31:0];
                return k;
            end
        end
        real_sz = wanted;
        return n;
    endfunction

    function automatic bit stash_handle(input int unsigned k, input logic [SW-1:0] h);
        if (k >= active_count())
            return 1'b0;
        if (stash_fill[k] >= depth_cap(k) || stash_fill[k] >= POOL_DEPTH)
            return 1'b0;
        stash[k][stash_fill[k]] = h;
        stash_fill[k]++;
        return 1'b1;
    endfunction

    function automatic bit take_handle(input int unsigned k, output logic [SW-1:0] h);
        if (k >= active_count() || stash_fill[k] == 0)
            return 1'b0;
        stash_fill[k]--;
        h = stash[k][stash_fill[k]];
        return 1'b1;
    endfunction

    // expected reply of the pool for one request word; updates the shadow stacks
    function automatic bit pool_serve(input logic [OW-1:0] op,
                                      input logic [SW-1:0] rq, hh, hr,
                                      output reply_t rep);
        int unsigned cls;
        int unsigned old_cls;
        logic [SW-1:0] csz;
        logic [SW-1:0] unused_sz;
        logic [SW-1:0] popped;
        rep = '0;
        if (op == OP_UNUSED)
            return 1'b0;
        if (op == p2bp_pkg::OP_FREE)
        begin
            cls = lookup_class(hr, csz);
            rep.status = stash_handle(cls, hh) ? p2bp_pkg::ST_PUSHED : p2bp_pkg::ST_RELEASE;
            rep.handle = hh;
            rep.buf_size = hr;
        end
        else if (op == p2bp_pkg::OP_RESIZE && rq <= hr)
        begin
            cls = lookup_class(hr, csz);
            rep.status = p2bp_pkg::ST_IN_PLACE;
            rep.handle = hh;
            rep.buf_size = hr;
            rep.size = rq;
        end
        else
        begin
            cls = lookup_class(rq, csz);
            rep.buf_size = csz;
            if (take_handle(cls, popped))
            begin
                rep.status = p2bp_pkg::ST_FROM_POOL;
                rep.handle = popped;
            end
            else
            begin
                rep.status = p2bp_pkg::ST_NEED_FRESH;
                rep.handle = '0;
            end
            rep.size = rq;
            // moving resize: the old buffer goes back after the new one is taken
            if (op == p2bp_pkg::OP_RESIZE)
            begin
                old_cls = lookup_class(hr, unused_sz);
                rep.released = !stash_handle(old_cls, hh);
            end
        end
        rep.cls = cls[p2bp_pkg::CLASS_W-1:0];
        return 1'b1;
    endfunction

    function automatic void match_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: reply %0d %s mismatch: expected %h, actual %h",
                     $time, replies_checked, name, want, got);
            fail_count++;
        end
    endfunction

    // checks every reply word against the oldest expectation
    always @(posedge clk)
    begin
        reply_t want;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (rsp_ch.status == p2bp_pkg::ST_RELEASE || rsp_ch.old_released === 1'b1)
                releases_seen++;
            if (pool_replies_due.size() == 0)
            begin
                $display("%0t: unexpected reply: expected none, actual status %0d handle %h",
                         $time, rsp_ch.status, rsp_ch.out_handle);
                fail_count++;
            end
            else
            begin
                want = pool_replies_due.pop_front();
                match_field("status", 32'(want.status), 32'(rsp_ch.status));
                match_field("out_handle", want.handle, rsp_ch.out_handle);
                match_field("out_real_size", want.buf_size, rsp_ch.out_real_size);
                match_field("out_size", want.size, rsp_ch.out_size);
                match_field("class_index", 32'(want.cls), 32'(rsp_ch.class_index));
                match_field("old_released", 32'(want.released), 32'(rsp_ch.old_released));
                replies_checked++;
            end
        end
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 9);
        end
    end

    task automatic send_word(input logic [OW-1:0] op, input logic [SW-1:0] rq, hh, hr,
                             output reply_t rep);
        if (!calm && $urandom_range(0, 99) < 15)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= op;
        req_ch.request_size <= rq;
        req_ch.held_handle <= hh;
        req_ch.held_real_size <= hr;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        if (pool_serve(op, rq, hh, hr, rep))
            pool_replies_due.push_back(rep);
        else
            ignored_sent++;
        words_sent++;
    endtask

    // stop sending and let the pool drain before touching registers
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pool_replies_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_access(input bit wr, input p2bp_pkg::reg_idx_t idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rdata = prdata;
    endtask

    task automatic check_regs(input logic [p2bp_pkg::LOG2_CFG_W-1:0] l2,
                              input logic [p2bp_pkg::ACTIVE_CFG_W-1:0] act,
                              input logic [p2bp_pkg::DEPTH_CFG_W-1:0] dep);
        logic [31:0] want [3];
        logic [31:0] rd;
        want[0] = 32'(l2);
        want[1] = 32'(act);
        want[2] = 32'(dep);
        for (int i = 0; i < 3; i++)
        begin
            reg_access(1'b0, p2bp_pkg::reg_idx_t'(i), '0, rd);
            if (rd !== want[i])
            begin
                $display("%0t: register %0d readback mismatch: expected %h, actual %h",
                         $time, i, want[i], rd);
                fail_count++;
            end
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input logic [p2bp_pkg::LOG2_CFG_W-1:0] l2,
                              input logic [p2bp_pkg::ACTIVE_CFG_W-1:0] act,
                              input logic [p2bp_pkg::DEPTH_CFG_W-1:0] dep);
        logic [31:0] rd;
        settle();
        reg_access(1'b1, p2bp_pkg::REG_SMALLEST_LOG2, 32'(l2), rd);
        reg_access(1'b1, p2bp_pkg::REG_ACTIVE, 32'(act), rd);
        reg_access(1'b1, p2bp_pkg::REG_BASE_DEPTH, 32'(dep), rd);
        cfg_log2 = l2;
        cfg_active = act;
        cfg_depth = dep;
        settings_used++;
        check_regs(l2, act, dep);
    endtask

    // sizes clustered around the class boundaries of the current setting
    function automatic logic [SW-1:0] pick_size();
        int unsigned e;
        logic [63:0] p;
        logic [63:0] below;
        e = int'(cfg_log2) + $urandom_range(0, 18);
        if (e > 32)
            e = 32;
        p = 64'd1 << e;
        below = p - 64'd1;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return '0;
            2: return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
            3: return p[31:0] + 32'd1;
            default: return $urandom & below[31:0];
        endcase
    endfunction

    task automatic keep_buffer(input reply_t r);
        if (r.status == p2bp_pkg::ST_FROM_POOL)
        begin
            live_handles.push_back(r.handle);
            live_sizes.push_back(r.buf_size);
        end
        else if (r.status == p2bp_pkg::ST_NEED_FRESH)
        begin
            live_handles.push_back($urandom);
            live_sizes.push_back(r.buf_size);
        end
    endtask

    task automatic test_directed_basics();
        reply_t r;
        send_word(p2bp_pkg::OP_ALLOC, 32'd0, 32'd0, 32'd0, r);
        send_word(p2bp_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, r);
        send_word(p2bp_pkg::OP_ALLOC, 32'h0040_0000, 32'd0, 32'd0, r);
        send_word(p2bp_pkg::OP_ALLOC, 32'h0040_0001, 32'd0, 32'd0, r);
        send_word(p2bp_pkg::OP_FREE, 32'd0, 32'hFFFF_FFFF, 32'd32, r);
        send_word(p2bp_pkg::OP_ALLOC, 32'd17, 32'd0, 32'd0, r);
        send_word(p2bp_pkg::OP_FREE, 32'd0, 32'd0, 32'hFFFF_FFFF, r);
        send_word(p2bp_pkg::OP_RESIZE, 32'd10, 32'h1234_5678, 32'd32, r);
        send_word(p2bp_pkg::OP_RESIZE, 32'd32, 32'h1234_5678, 32'd32, r);
        send_word(p2bp_pkg::OP_RESIZE, 32'd100, 32'h1234_5678, 32'd32, r);
        send_word(p2bp_pkg::OP_RESIZE, 32'hFFFF_FFFF, 32'h0BAD_F00D, 32'h8000_0000, r);
        send_word(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, r);
        send_word(p2bp_pkg::OP_ALLOC, 32'd1, 32'd0, 32'd0, r);
    endtask

    task automatic test_class_extremes();
        reply_t r;
        // top class is 2^32 bytes: real size saturates
        set_config(4'd15, 5'd18, 7'd64);
        send_word(p2bp_pkg::OP_ALLOC, 32'h8000_0001, 32'd0, 32'd0, r);
        send_word(p2bp_pkg::OP_FREE, 32'd0, 32'h00C0_FFEE, 32'hFFFF_FFFF, r);
        send_word(p2bp_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'd0, 32'd0, r);
        set_config(4'd0, 5'd31, 7'd64);
        send_word(p2bp_pkg::OP_ALLOC, 32'h0002_0000, 32'd0, 32'd0, r);
        send_word(p2bp_pkg::OP_ALLOC, 32'h0002_0001, 32'd0, 32'd0, r);
        set_config(4'd0, 5'd0, 7'd64);
        send_word(p2bp_pkg::OP_ALLOC, 32'd0, 32'd0, 32'd0, r);
        send_word(p2bp_pkg::OP_FREE, 32'd0, 32'h5A5A_5A5A, 32'd0, r);
    endtask

    task automatic test_stack_limits();
        reply_t r;
        set_config(4'd5, 5'd18, 7'd2);
        send_word(p2bp_pkg::OP_FREE, 32'd0, 32'h0000_0101, 32'd1, r);
        send_word(p2bp_pkg::OP_FREE, 32'd0, 32'h0000_0102, 32'd1, r);
        send_word(p2bp_pkg::OP_FREE, 32'd0, 32'h0000_0103, 32'd1, r);
        // limit shrinks below the current fill
        set_config(4'd5, 5'd18, 7'd1);
        send_word(p2bp_pkg::OP_FREE, 32'd0, 32'h0000_0104, 32'd1, r);
        send_word(p2bp_pkg::OP_ALLOC, 32'd1, 32'd0, 32'd0, r);
        set_config(4'd5, 5'd18, 7'd8);
        send_word(p2bp_pkg::OP_FREE, 32'd0, 32'h0000_0201, 32'h0010_0000, r);
        send_word(p2bp_pkg::OP_FREE, 32'd0, 32'h0000_0202, 32'h0010_0000, r);
    endtask

    // mostly alloc/free/resize on buffers actually held, with some noise
    task automatic test_random_traffic(input int unsigned words);
        reply_t r;
        int unsigned done;
        int unsigned pick;
        int unsigned idx;
        logic [OW-1:0] op;
        logic [SW-1:0] rq;
        done = 0;
        while (done < words)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                op = OW'($urandom_range(0, 3));
                send_word(op, pick_size(), $urandom, $urandom, r);
                if (op != OP_UNUSED)
                    done++;
            end
            else if (live_handles.size() == 0 || (pick < 43 && live_handles.size() < 150))
            begin
                send_word(p2bp_pkg::OP_ALLOC, pick_size(), $urandom, $urandom, r);
                keep_buffer(r);
                done++;
            end
            else if (pick < 75 || live_handles.size() >= 150)
            begin
                idx = $urandom_range(0, live_handles.size() - 1);
                send_word(p2bp_pkg::OP_FREE, $urandom, live_handles[idx], live_sizes[idx], r);
                live_handles.delete(idx);
                live_sizes.delete(idx);
                done++;
            end
            else
            begin
                idx = $urandom_range(0, live_handles.size() - 1);
                rq = $urandom_range(0, 1) ? $urandom_range(0, live_sizes[idx]) : pick_size();
                send_word(p2bp_pkg::OP_RESIZE, rq, live_handles[idx], live_sizes[idx], r);
                if (r.status != p2bp_pkg::ST_IN_PLACE)
                begin
                    live_handles.delete(idx);
                    live_sizes.delete(idx);
                    keep_buffer(r);
                end
                done++;
            end
        end
    endtask

    initial
    begin
        logic [p2bp_pkg::LOG2_CFG_W-1:0]   phase_log2   [7] =
            '{4'd5, 4'd0, 4'd2, 4'd15, 4'd14, 4'd0, 4'd4};
        logic [p2bp_pkg::ACTIVE_CFG_W-1:0] phase_active [7] =
            '{5'd18, 5'd1, 5'd6, 5'd31, 5'd18, 5'd8, 5'd12};
        logic [p2bp_pkg::DEPTH_CFG_W-1:0]  phase_depth  [7] =
            '{7'd64, 7'd0, 7'd3, 7'd127, 7'd16, 7'd1, 7'd9};
        for (int k = 0; k < POOL_CLASSES; k++)
            stash_fill[k] = 0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.operation <= p2bp_pkg::OP_ALLOC;
        req_ch.request_size <= '0;
        req_ch.held_handle <= '0;
        req_ch.held_real_size <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_regs(p2bp_pkg::RST_SMALLEST_LOG2, p2bp_pkg::RST_ACTIVE,
                   p2bp_pkg::RST_BASE_DEPTH);
        test_directed_basics();
        test_class_extremes();
        test_stack_limits();
        for (int p = 0; p < 7; p++)
        begin
            set_config(phase_log2[p], phase_active[p], phase_depth[p]);
            calm = (p == 0);
            test_random_traffic(PHASE_WORDS);
        end
        calm = 1'b0;
        settle();

        $display("Covered %0d request words (%0d with the unused code) across %0d pool settings.",
                 words_sent, ignored_sent, settings_used);
        $display("Checked %0d replies; %0d of them sent a buffer back to the system.",
                 replies_checked, releases_seen);
        if (fail_count == 0)
            $display("tb_pow2_size_class_buffer_pool: PASS");
        else
            $display("tb_pow2_size_class_buffer_pool: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
design/p2bp_pkg.sv
design/p2bp_req_if.sv
design/p2bp_rsp_if.sv
design/p2bp_ram.sv
design/p2bp_regs.sv
design/p2bp_ctrl.sv
design/p2bp_dp.sv
design/pow2_size_class_buffer_pool.sv
test/tb_pow2_size_class_buffer_pool.sv
